FILE: rtl/core/slmi_pkg.sv
// Shared types, widths and codes of the sprite linear motion interpolator.
package slmi_pkg;

  localparam int COORD_W        = 24;
  localparam int QW             = COORD_W + 1;
  localparam int CNT_W          = $clog2(QW);
  localparam int RECT_W         = 17;
  localparam int SIZE_W         = 7;
  localparam int SPEED_W        = 16;
  localparam int DUR_W          = 16;
  localparam int OP_W           = 3;
  localparam int LEFT_W         = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int FRAME_BITS_DEF = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_PLACE    = 3'd1,
    OP_GO_TIME  = 3'd2,
    OP_GO_SPEED = 3'd3,
    OP_MOVE_BY  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_APPLY,
    CMD_POS_MUL,
    CMD_DIV_STEP,
    CMD_POS_FIN,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_SQRT_STEP,
    CMD_NDIV_LOAD,
    CMD_OUT_LOAD
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    axis;
  } ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            out_free;
  } status_t;

endpackage

FILE: rtl/core/sprite_linear_motion_interpolator.sv
// Sprite linear motion interpolator top level: controller, datapath and checks.
// Usage: one request enters on the input channel (valid/ready) with an opcode
// that advances the frame, places the sprite or sets a new goal. Each request
// gives one result on the output channel (valid/ready): the interpolated
// position, the drawn rectangle and the frames left until arrival.
// The block handles one request at a time; in_ready_o is high only while idle.
// Every request interpolates both axes of the position through the shared
// restoring divider; go_at_speed and move_by also use the 25 step square root
// unit and a frame count division on that same divider.
// The next request is taken in the cycle after the result is loaded.
// When the receiver stalls, the result waits in the output register and the
// block holds the finished request until that register frees.
// Reset clears the frame counter and the motion to zero and sets the sprite
// size to 8; cfg_we_i writes the sprite size at any clock edge.
module sprite_linear_motion_interpolator import slmi_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [SIZE_W-1:0]          cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            opcode_i,
  input  logic signed [COORD_W-1:0]  target_x_i,
  input  logic signed [COORD_W-1:0]  target_y_i,
  input  logic [SPEED_W-1:0]         speed_i,
  input  logic [DUR_W-1:0]           duration_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COORD_W-1:0]  screen_x_o,
  output logic signed [COORD_W-1:0]  screen_y_o,
  output logic signed [RECT_W-1:0]   rect_left_o,
  output logic signed [RECT_W-1:0]   rect_top_o,
  output logic signed [RECT_W-1:0]   rect_right_o,
  output logic signed [RECT_W-1:0]   rect_bottom_o,
  output logic [LEFT_W-1:0]          frames_left_o
);

  ctrl_t   ctrl;
  status_t stat;

  slmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  slmi_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .speed_i       (speed_i),
    .duration_i    (duration_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .rect_left_o   (rect_left_o),
    .rect_top_o    (rect_top_o),
    .rect_right_o  (rect_right_o),
    .rect_bottom_o (rect_bottom_o),
    .frames_left_o (frames_left_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a request");

  a_rect_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (RECT_W'(rect_right_o - rect_left_o) == RECT_W'(rect_bottom_o - rect_top_o)))
    else $error("rectangle width and height differ");

  a_left_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !frames_left_o[LEFT_W-1])
    else $error("frames left exceeds the saturated move length");
`endif

endmodule

FILE: rtl/core/slmi_ctrl.sv
// Sequencing state machine of the sprite linear motion interpolator.
module slmi_ctrl import slmi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o,
  input  status_t stat_i
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_DECODE    = 12'b000000000010,
    S_POS_MUL   = 12'b000000000100,
    S_POS_DIV   = 12'b000000001000,
    S_POS_FIN   = 12'b000000010000,
    S_SQ_X      = 12'b000000100000,
    S_SQ_Y      = 12'b000001000000,
    S_SQRT      = 12'b000010000000,
    S_NDIV_LOAD = 12'b000100000000,
    S_NDIV      = 12'b001000000000,
    S_APPLY     = 12'b010000000000,
    S_OUT       = 12'b100000000000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              axis_q, axis_d;
  logic              applied_q, applied_d;
  logic              is_tick, is_speed;

  assign is_tick  = (stat_i.op == OP_TICK);
  assign is_speed = (stat_i.op == OP_GO_SPEED) || (stat_i.op == OP_MOVE_BY);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    applied_d   = applied_q;
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_CAPTURE;
          applied_d  = 1'b0;
          axis_d     = 1'b0;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = is_tick ? S_APPLY : S_POS_MUL;
      end
      S_POS_MUL: begin
        ctrl_o.cmd = CMD_POS_MUL;
        cnt_d      = CNT_W'(QW - 1);
        state_d    = S_POS_DIV;
      end
      S_POS_DIV: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_POS_FIN;
      end
      S_POS_FIN: begin
        ctrl_o.cmd = CMD_POS_FIN;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = S_POS_MUL;
        end else begin
          axis_d = 1'b0;
          if (applied_q) state_d = S_OUT;
          else if (is_speed) state_d = S_SQ_X;
          else state_d = S_APPLY;
        end
      end
      S_SQ_X: begin
        ctrl_o.cmd = CMD_SQ_X;
        state_d    = S_SQ_Y;
      end
      S_SQ_Y: begin
        ctrl_o.cmd = CMD_SQ_Y;
        cnt_d      = CNT_W'(QW - 1);
        state_d    = S_SQRT;
      end
      S_SQRT: begin
        ctrl_o.cmd = CMD_SQRT_STEP;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_NDIV_LOAD;
      end
      S_NDIV_LOAD: begin
        ctrl_o.cmd = CMD_NDIV_LOAD;
        cnt_d      = CNT_W'(QW - 1);
        state_d    = S_NDIV;
      end
      S_NDIV: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_APPLY;
      end
      S_APPLY: begin
        ctrl_o.cmd = CMD_APPLY;
        applied_d  = 1'b1;
        state_d    = is_tick ? S_POS_MUL : S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_OUT_LOAD;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      axis_q    <= 1'b0;
      applied_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      axis_q    <= axis_d;
      applied_q <= applied_d;
    end
  end

endmodule

FILE: rtl/core/slmi_dp.sv
// Datapath of the sprite linear motion interpolator: state, divider, square root, outputs.
module slmi_dp import slmi_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  output status_t                    stat_o,
  input  logic                       cfg_we_i,
  input  logic [SIZE_W-1:0]          cfg_wdata_i,
  input  logic [OP_W-1:0]            opcode_i,
  input  logic signed [COORD_W-1:0]  target_x_i,
  input  logic signed [COORD_W-1:0]  target_y_i,
  input  logic [SPEED_W-1:0]         speed_i,
  input  logic [DUR_W-1:0]           duration_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COORD_W-1:0]  screen_x_o,
  output logic signed [COORD_W-1:0]  screen_y_o,
  output logic signed [RECT_W-1:0]   rect_left_o,
  output logic signed [RECT_W-1:0]   rect_top_o,
  output logic signed [RECT_W-1:0]   rect_right_o,
  output logic signed [RECT_W-1:0]   rect_bottom_o,
  output logic [LEFT_W-1:0]          frames_left_o
);

  localparam int FB = FRAME_BITS;
  localparam int PW = QW + FB;
  localparam int SW = QW + 2;
  localparam logic [COORD_W-1:0] FRAC_MASK = (COORD_W'(1) << FRAC_BITS) - COORD_W'(1);
  localparam logic [63:0] MAXN = (64'(1) << (FB - 1)) - 64'(1);
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] whole_pixel(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] sh;
    logic                      adj;
    sh  = v >>> FRAC_BITS;
    adj = v[COORD_W-1] && ((v & FRAC_MASK) != '0);
    return sh + COORD_W'(adj);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_sum(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) return s[COORD_W] ? C_MIN : C_MAX;
    return s[COORD_W-1:0];
  endfunction

  logic [FB-1:0]              frame_q, sf_q, af_q;
  logic signed [COORD_W-1:0]  sx_q, sy_q, gx_q, gy_q;
  logic [SIZE_W-1:0]          size_q;
  logic                       oval_q;

  logic [OP_W-1:0]            op_q;
  logic signed [COORD_W-1:0]  tx_q, ty_q, px_q, py_q;
  logic [SPEED_W-1:0]         spd_q;
  logic [DUR_W-1:0]           dur_q;
  logic [FB-1:0]              rem_q, dv_q;
  logic [QW-1:0]              quo_q, root_q;
  logic [2*QW-1:0]            sq_q, rad_q;
  logic [SW-1:0]              srem_q;

  logic [FB-1:0]              left, total, left_c;
  logic                       arrived, at_start;
  logic signed [COORD_W-1:0]  s_sel, g_sel, pos_new;
  logic [QW-1:0]              diff, mag;
  logic                       neg;
  logic [PW-1:0]              prod;
  logic [COORD_W+1:0]         fin_sum;
  logic [FB:0]                dt, dsub;
  logic                       dge;
  logic [QW-1:0]              dxv, dyv, dsel, usel;
  logic [2*QW-1:0]            usq;
  logic [SW-1:0]              rsh, trial;
  logic                       rge;
  logic [QW-1:0]              n_raw;
  logic [63:0]                n_ext;
  logic [FB-1:0]              n_f;
  logic signed [COORD_W-1:0]  gxn, gyn, sxn, syn;
  logic                       is_set;
  logic signed [COORD_W-1:0]  wx, wy;
  logic [RECT_W-1:0]          half;

  assign left     = af_q - frame_q;
  assign total    = af_q - sf_q;
  assign arrived  = left[FB-1] || (left == '0) || total[FB-1] || (total == '0);
  assign at_start = $signed(left) >= $signed(total);
  assign left_c   = left[FB-1] ? '0 : left;

  assign s_sel   = ctrl_i.axis ? sy_q : sx_q;
  assign g_sel   = ctrl_i.axis ? gy_q : gx_q;
  assign diff    = {g_sel[COORD_W-1], g_sel} - {s_sel[COORD_W-1], s_sel};
  assign neg     = diff[QW-1];
  assign mag     = neg ? (QW'(0) - diff) : diff;
  assign prod    = PW'(mag) * PW'(left);
  assign fin_sum = neg ? ({{2{g_sel[COORD_W-1]}}, g_sel} + {1'b0, quo_q})
                       : ({{2{g_sel[COORD_W-1]}}, g_sel} - {1'b0, quo_q});
  assign pos_new = arrived ? g_sel : (at_start ? s_sel : fin_sum[COORD_W-1:0]);

  assign dt   = {rem_q, quo_q[QW-1]};
  assign dge  = dt >= {1'b0, dv_q};
  assign dsub = dt - {1'b0, dv_q};

  assign dxv  = (op_q == OP_MOVE_BY) ? {tx_q[COORD_W-1], tx_q}
                                     : ({tx_q[COORD_W-1], tx_q} - {px_q[COORD_W-1], px_q});
  assign dyv  = (op_q == OP_MOVE_BY) ? {ty_q[COORD_W-1], ty_q}
                                     : ({ty_q[COORD_W-1], ty_q} - {py_q[COORD_W-1], py_q});
  assign dsel = (ctrl_i.cmd == CMD_SQ_Y) ? dyv : dxv;
  assign usel = dsel[QW-1] ? (QW'(0) - dsel) : dsel;
  assign usq  = (2*QW)'(usel) * (2*QW)'(usel);

  assign rsh   = {srem_q[QW-1:0], rad_q[2*QW-1:2*QW-2]};
  assign trial = {root_q, 2'b01};
  assign rge   = rsh >= trial;

  always_comb begin
    unique case (op_q)
      OP_GO_TIME:              n_raw = QW'(dur_q);
      OP_GO_SPEED, OP_MOVE_BY: n_raw = (spd_q == '0) ? '0 : quo_q;
      default:                 n_raw = '0;
    endcase
    n_ext = 64'(n_raw);
    if (n_ext > MAXN) n_ext = MAXN;
    n_f = n_ext[FB-1:0];
  end

  assign is_set = (op_q == OP_PLACE) || (op_q == OP_GO_TIME) || (op_q == OP_GO_SPEED)
               || (op_q == OP_MOVE_BY);
  assign gxn = (op_q == OP_MOVE_BY) ? sat_sum(px_q, tx_q) : tx_q;
  assign gyn = (op_q == OP_MOVE_BY) ? sat_sum(py_q, ty_q) : ty_q;
  assign sxn = (n_f == '0) ? gxn : px_q;
  assign syn = (n_f == '0) ? gyn : py_q;

  assign wx   = whole_pixel(px_q);
  assign wy   = whole_pixel(py_q);
  assign half = RECT_W'(size_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      sf_q    <= '0;
      af_q    <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      gx_q    <= '0;
      gy_q    <= '0;
      size_q  <= SIZE_RESET;
      oval_q  <= 1'b0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (ctrl_i.cmd == CMD_OUT_LOAD) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
      if (ctrl_i.cmd == CMD_APPLY) begin
        if (op_q == OP_TICK) begin
          frame_q <= frame_q + 1'b1;
        end else if (is_set) begin
          sx_q <= sxn;
          sy_q <= syn;
          gx_q <= gxn;
          gy_q <= gyn;
          sf_q <= frame_q;
          af_q <= frame_q + n_f;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_CAPTURE: begin
        op_q  <= opcode_i;
        tx_q  <= target_x_i;
        ty_q  <= target_y_i;
        spd_q <= speed_i;
        dur_q <= duration_i;
      end
      CMD_POS_MUL: begin
        rem_q <= prod[PW-1:QW];
        quo_q <= prod[QW-1:0];
        dv_q  <= total;
      end
      CMD_DIV_STEP: begin
        rem_q <= dge ? dsub[FB-1:0] : dt[FB-1:0];
        quo_q <= {quo_q[QW-2:0], dge};
      end
      CMD_POS_FIN: begin
        if (ctrl_i.axis) py_q <= pos_new;
        else px_q <= pos_new;
      end
      CMD_SQ_X: sq_q <= usq;
      CMD_SQ_Y: begin
        rad_q  <= sq_q + usq;
        srem_q <= '0;
        root_q <= '0;
      end
      CMD_SQRT_STEP: begin
        srem_q <= rge ? (rsh - trial) : rsh;
        root_q <= {root_q[QW-2:0], rge};
        rad_q  <= {rad_q[2*QW-3:0], 2'b00};
      end
      CMD_NDIV_LOAD: begin
        rem_q <= '0;
        quo_q <= root_q;
        dv_q  <= FB'(spd_q);
      end
      CMD_APPLY: begin
        if (is_set) begin
          px_q <= sxn;
          py_q <= syn;
        end
      end
      CMD_OUT_LOAD: begin
        screen_x_o    <= px_q;
        screen_y_o    <= py_q;
        rect_left_o   <= RECT_W'(wx) - half;
        rect_right_o  <= RECT_W'(wx) + half;
        rect_top_o    <= RECT_W'(wy) - half;
        rect_bottom_o <= RECT_W'(wy) + half;
        frames_left_o <= LEFT_W'(left_c);
      end
      default: ;
    endcase
  end

  assign out_valid_o     = oval_q;
  assign stat_o.op       = op_q;
  assign stat_o.out_free = !oval_q || out_ready_i;

endmodule

FILE: sim/slmi_checker.sv
// Checker that predicts every sprite motion result and compares it with the block's output.
module slmi_checker import slmi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SIZE_W-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [OP_W-1:0]           opcode_i,
  input  logic signed [COORD_W-1:0] target_x_i,
  input  logic signed [COORD_W-1:0] target_y_i,
  input  logic [SPEED_W-1:0]        speed_i,
  input  logic [DUR_W-1:0]          duration_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [COORD_W-1:0] screen_x_i,
  input  logic signed [COORD_W-1:0] screen_y_i,
  input  logic signed [RECT_W-1:0]  rect_left_i,
  input  logic signed [RECT_W-1:0]  rect_top_i,
  input  logic signed [RECT_W-1:0]  rect_right_i,
  input  logic signed [RECT_W-1:0]  rect_bottom_i,
  input  logic [LEFT_W-1:0]         frames_left_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [RECT_W-1:0]  left;
    logic signed [RECT_W-1:0]  top;
    logic signed [RECT_W-1:0]  right;
    logic signed [RECT_W-1:0]  bottom;
    logic [LEFT_W-1:0]         frames;
  } pose_t;

  localparam longint FRAME_SAT = 64'h7FFF_FFFF;

  pose_t pose_q[$];
  logic [31:0] frame_now, start_frame, arrival_frame;
  longint start_x, start_y, goal_x, goal_y;
  logic [SIZE_W-1:0] size_reg;

  function automatic longint span(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return longint'($signed(d));
  endfunction

  function automatic longint axis_pos(longint s, longint g);
    longint lft, tot;
    lft = span(arrival_frame, frame_now);
    tot = span(arrival_frame, start_frame);
    if (lft <= 0 || tot <= 0) return g;
    if (lft >= tot) return s;
    return g - ((g - s) * lft) / tot;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint travel_frames(longint dx, longint dy, longint spd);
    longint unsigned v, r, b;
    if (spd == 0) return 0;
    v = longint'(dx * dx + dy * dy);
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r / longint'(spd));
  endfunction

  task automatic aim(longint gx, longint gy, longint n, longint px, longint py);
    if (n > FRAME_SAT) n = FRAME_SAT;
    start_x = (n == 0) ? gx : px;
    start_y = (n == 0) ? gy : py;
    goal_x = gx;
    goal_y = gy;
    start_frame = frame_now;
    arrival_frame = frame_now + 32'(n);
  endtask

  task automatic predict_motion(op_e op, longint tx, longint ty, longint spd, longint dur);
    longint px, py, lft, half, wx, wy;
    pose_t p;
    px = axis_pos(start_x, goal_x);
    py = axis_pos(start_y, goal_y);
    case (op)
      OP_TICK: frame_now = frame_now + 1;
      OP_PLACE: aim(tx, ty, 0, px, py);
      OP_GO_TIME: aim(tx, ty, dur, px, py);
      OP_GO_SPEED: aim(tx, ty, travel_frames(tx - px, ty - py, spd), px, py);
      OP_MOVE_BY: aim(clamp_coord(px + tx), clamp_coord(py + ty),
                      travel_frames(tx, ty, spd), px, py);
      default: ;
    endcase
    px = axis_pos(start_x, goal_x);
    py = axis_pos(start_y, goal_y);
    lft = span(arrival_frame, frame_now);
    if (lft < 0) lft = 0;
    half = longint'(size_reg >> 1);
    wx = px / 256;
    wy = py / 256;
    p.sx = COORD_W'(px);
    p.sy = COORD_W'(py);
    p.left = RECT_W'(wx - half);
    p.top = RECT_W'(wy - half);
    p.right = RECT_W'(wx + half);
    p.bottom = RECT_W'(wy + half);
    p.frames = LEFT_W'(lft);
    pose_q.push_back(p);
  endtask

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      frame_now = 0;
      start_frame = 0;
      arrival_frame = 0;
      start_x = 0;
      start_y = 0;
      goal_x = 0;
      goal_y = 0;
      size_reg = SIZE_RESET;
      pose_q.delete();
      fail_count_o = 0;
      results_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (pose_q.size() == 0) begin
          $error("result with no request pending");
          fail_count_o++;
        end else begin
          e = pose_q.pop_front();
          compare_field("screen_x", e.sx, screen_x_i);
          compare_field("screen_y", e.sy, screen_y_i);
          compare_field("rect_left", e.left, rect_left_i);
          compare_field("rect_top", e.top, rect_top_i);
          compare_field("rect_right", e.right, rect_right_i);
          compare_field("rect_bottom", e.bottom, rect_bottom_i);
          compare_field("frames_left", e.frames, frames_left_i);
        end
      end
      if (in_valid_i && in_ready_i)
        predict_motion(op_e'(opcode_i), target_x_i, target_y_i, speed_i, duration_i);
      if (cfg_we_i) size_reg = cfg_wdata_i;
      pending_o = pose_q.size();
    end
  end
endmodule

FILE: sim/testbench.sv
// Stimulus and verdict for the sprite linear motion interpolator.
module testbench import slmi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OP_W-1:0] opcode_i = '0;
  logic signed [COORD_W-1:0] target_x_i = '0;
  logic signed [COORD_W-1:0] target_y_i = '0;
  logic [SPEED_W-1:0] speed_i = '0;
  logic [DUR_W-1:0] duration_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] screen_x_o, screen_y_o;
  logic signed [RECT_W-1:0] rect_left_o, rect_top_o, rect_right_o, rect_bottom_o;
  logic [LEFT_W-1:0] frames_left_o;
  int fail_count, pending, results;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int ops_seen[8];

  localparam int CYCLE_LIMIT = 3_000_000;

  always #1 clk_i = ~clk_i;

  sprite_linear_motion_interpolator u_dut (.*);

  slmi_checker u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .opcode_i, .target_x_i, .target_y_i, .speed_i,
    .duration_i, .out_valid_i(out_valid_o), .out_ready_i,
    .screen_x_i(screen_x_o), .screen_y_i(screen_y_o),
    .rect_left_i(rect_left_o), .rect_top_i(rect_top_o),
    .rect_right_i(rect_right_o), .rect_bottom_i(rect_bottom_o),
    .frames_left_i(frames_left_o), .fail_count_o(fail_count),
    .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver stalls in random bursts, or for a long stretch on request.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] tx,
                              logic signed [COORD_W-1:0] ty, logic [SPEED_W-1:0] spd,
                              logic [DUR_W-1:0] dur);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    target_x_i <= tx;
    target_y_i <= ty;
    speed_i <= spd;
    duration_i <= dur;
    ops_seen[op]++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (130) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return COORD_W'($urandom);
      default: return COORD_W'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    int r;
    logic [SIZE_W-1:0] sizes[5] = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd8};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_TICK, '0, '0, '0, '0);
    send_request(OP_PLACE, 24'sh7FFFFF, 24'sh800000, '0, '0);
    send_request(OP_GO_TIME, 24'sh800000, 24'sh7FFFFF, '0, 16'd4);
    repeat (2) send_request(OP_TICK, '0, '0, '0, '0);
    send_request(OP_GO_TIME, '0, '0, '0, 16'hFFFF);
    send_request(OP_TICK, '0, '0, '0, '0);
    send_request(OP_GO_SPEED, 24'sh001000, -24'sh002000, 16'd0, '0);
    send_request(OP_GO_SPEED, 24'sh7FFFFF, 24'sh7FFFFF, 16'd1, '0);
    send_request(OP_TICK, '0, '0, '0, '0);
    send_request(OP_GO_SPEED, 24'sh800000, 24'sh800000, 16'hFFFF, '0);
    send_request(OP_MOVE_BY, 24'sh7FFFFF, 24'sh7FFFFF, 16'd256, '0);
    send_request(OP_MOVE_BY, 24'sh800000, 24'sh800000, 16'd0, '0);
    send_request(OP_MOVE_BY, 24'sh000100, 24'sh000000, 16'd512, '0);
    send_request(3'd5, '0, '0, '0, '0);
    send_request(3'd7, 24'sh123456, 24'sh654321, 16'hFFFF, 16'hFFFF);
    send_request(OP_TICK, '0, '0, '0, '0);

    for (int phase = 0; phase < 5; phase++) begin
      write_size(sizes[phase]);
      if (phase == 2) hold_off = 1'b1;
      if (phase == 4) calm = 1'b1;
      for (int i = 0; i < 320; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_TICK;
        else if (r < 53) op = OP_PLACE;
        else if (r < 68) op = OP_GO_TIME;
        else if (r < 80) op = OP_GO_SPEED;
        else if (r < 95) op = OP_MOVE_BY;
        else op = OP_W'($urandom_range(5, 7));
        send_request(op, rand_coord(), rand_coord(),
                     ($urandom_range(0, 3) == 0) ? SPEED_W'($urandom)
                                                 : SPEED_W'($urandom_range(0, 300)),
                     ($urandom_range(0, 5) == 0) ? DUR_W'($urandom)
                                                 : DUR_W'($urandom_range(0, 20)));
      end
    end

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (130) @(posedge clk_i);
    $display("Checked %0d results over five sprite sizes, with %0d ticks and %0d moves.",
             results, ops_seen[OP_TICK], results - ops_seen[OP_TICK]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
